>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL; clock and reset names follow the house ports.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
    `ASSERT_CLK(lbl, !(cond), msg)

`endif

>>> hw/rtl/itoa_pkg.sv
package itoa_pkg;

    localparam int ValueW    = 32;
    localparam int CmdW      = 2;
    localparam int CharW     = 7;
    localparam int BcdDigits = 10;
    localparam int BcdW      = 4 * BcdDigits;
    localparam int CntW      = 5;
    localparam int PcW       = 4;

    // format commands
    typedef enum logic [CmdW-1:0] {
        CMD_BIN  = 2'd0,
        CMD_DEC  = 2'd1,
        CMD_HEX  = 2'd2,
        CMD_SWAP = 2'd3
    } t_cmd;

    // character source of a microcode step
    typedef enum logic [2:0] {
        EM_NONE    = 3'd0,
        EM_ZERO    = 3'd1,
        EM_PREFIX  = 3'd2,
        EM_MINUS   = 3'd3,
        EM_DIGIT   = 3'd4,
        EM_NEWLINE = 3'd5
    } t_emit;

    // datapath operation of a microcode step
    typedef enum logic [2:0] {
        OP_NOP     = 3'd0,
        OP_LOAD    = 3'd1,
        OP_DABBLE  = 3'd2,
        OP_SET_DIG = 3'd3,
        OP_SKIP    = 3'd4,
        OP_SHIFT   = 3'd5
    } t_op;

    // branch condition of a microcode step
    typedef enum logic [1:0] {
        CND_INPUT    = 2'd0,
        CND_ALWAYS   = 2'd1,
        CND_CNT_ZERO = 2'd2,
        CND_TOP_DONE = 2'd3
    } t_cond;

    typedef struct packed {
        t_emit          emit;
        t_op            op;
        t_cond          cond;
        logic [PcW-1:0] target;
    } t_uword;

    // sequencer -> datapath
    typedef struct packed {
        logic fire;
        t_op  op;
    } t_dp_ctl;

    // datapath -> sequencer
    typedef struct packed {
        logic       cnt_zero;
        logic       top_done;
        logic       is_bin;
        logic [3:0] digit;
    } t_dp_stat;

    // program addresses
    localparam logic [PcW-1:0] ST_IDLE   = 4'd0;
    localparam logic [PcW-1:0] ST_ZERO   = 4'd1;
    localparam logic [PcW-1:0] ST_PREFIX = 4'd2;
    localparam logic [PcW-1:0] ST_MINUS  = 4'd3;
    localparam logic [PcW-1:0] ST_DABBLE = 4'd4;
    localparam logic [PcW-1:0] ST_SET    = 4'd5;
    localparam logic [PcW-1:0] ST_SKIP   = 4'd6;
    localparam logic [PcW-1:0] ST_DIGIT  = 4'd7;
    localparam logic [PcW-1:0] ST_NL     = 4'd8;

    // ASCII codes
    localparam logic [CharW-1:0] ChZero      = 7'h30;
    localparam logic [CharW-1:0] ChB         = 7'h62;
    localparam logic [CharW-1:0] ChX         = 7'h78;
    localparam logic [CharW-1:0] ChMinus     = 7'h2d;
    localparam logic [CharW-1:0] ChNewline   = 7'h0a;
    localparam logic [CharW-1:0] HexLetterOff = 7'd87;

    // digit counter start values (count minus one)
    localparam logic [CntW-1:0] CntBin = CntW'(ValueW - 1);
    localparam logic [CntW-1:0] CntHex = CntW'(ValueW / 4 - 1);
    localparam logic [CntW-1:0] CntDab = CntW'(ValueW - 1);
    localparam logic [CntW-1:0] CntBcd = CntW'(BcdDigits - 1);

    // control store
    function automatic t_uword ucode(input logic [PcW-1:0] pc);
        t_uword w;
        w = '{emit: EM_NONE, op: OP_NOP, cond: CND_INPUT, target: ST_IDLE};
        unique case (pc)
            ST_IDLE:   w = '{emit: EM_NONE,    op: OP_LOAD,    cond: CND_INPUT,
                             target: ST_IDLE};
            ST_ZERO:   w = '{emit: EM_ZERO,    op: OP_NOP,     cond: CND_ALWAYS,
                             target: ST_PREFIX};
            ST_PREFIX: w = '{emit: EM_PREFIX,  op: OP_NOP,     cond: CND_ALWAYS,
                             target: ST_SKIP};
            ST_MINUS:  w = '{emit: EM_MINUS,   op: OP_NOP,     cond: CND_ALWAYS,
                             target: ST_DABBLE};
            ST_DABBLE: w = '{emit: EM_NONE,    op: OP_DABBLE,  cond: CND_CNT_ZERO,
                             target: ST_SET};
            ST_SET:    w = '{emit: EM_NONE,    op: OP_SET_DIG, cond: CND_ALWAYS,
                             target: ST_SKIP};
            ST_SKIP:   w = '{emit: EM_NONE,    op: OP_SKIP,    cond: CND_TOP_DONE,
                             target: ST_DIGIT};
            ST_DIGIT:  w = '{emit: EM_DIGIT,   op: OP_SHIFT,   cond: CND_CNT_ZERO,
                             target: ST_NL};
            ST_NL:     w = '{emit: EM_NEWLINE, op: OP_NOP,     cond: CND_ALWAYS,
                             target: ST_IDLE};
            default:   w = '{emit: EM_NONE,    op: OP_NOP,     cond: CND_ALWAYS,
                             target: ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

>>> hw/rtl/itoa_datapath.sv
`include "assert_macros.svh"

module itoa_datapath
    import itoa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [ValueW-1:0] i_value,
    input  t_cmd              i_cmd,
    input  t_dp_ctl           i_ctl,
    output t_dp_stat          o_stat
);

    logic [BcdW-1:0]   r_sh;    // BCD digits or left-aligned binary word
    logic [ValueW-1:0] r_val;   // binary bits feeding the double-dabble
    logic [CntW-1:0]   r_cnt;
    logic              r_bin;

    logic [BcdW-1:0]   adj;
    logic [BcdW-1:0]   sh_digit;
    logic [3:0]        top;
    logic              cnt_zero;
    logic              top_done;
    logic [ValueW-1:0] dec_val;

    // add-3 correction on every BCD digit
    always_comb begin
        for (int i = 0; i < BcdDigits; i++) begin
            adj[4*i +: 4] = (r_sh[4*i +: 4] >= 4'd5) ? r_sh[4*i +: 4] + 4'd3
                                                     : r_sh[4*i +: 4];
        end
    end

    // top digit and one-digit shift
    assign top      = r_bin ? {3'b000, r_sh[BcdW-1]} : r_sh[BcdW-1 -: 4];
    assign sh_digit = r_bin ? {r_sh[BcdW-2:0], 1'b0} : {r_sh[BcdW-5:0], 4'b0000};
    assign cnt_zero = (r_cnt == '0);
    assign top_done = (top != 4'd0) || cnt_zero;

    // magnitude for signed decimal, byte reversal for swapped mode
    always_comb begin
        if (i_cmd == CMD_DEC) begin
            dec_val = i_value[ValueW-1] ? (~i_value + 32'd1) : i_value;
        end else begin
            dec_val = {i_value[7:0], i_value[15:8], i_value[23:16], i_value[31:24]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_bin <= 1'b0;
        end else if (i_ctl.fire) begin
            case (i_ctl.op)
                OP_LOAD: begin
                    r_bin <= (i_cmd == CMD_BIN);
                    if (i_cmd == CMD_BIN || i_cmd == CMD_HEX) begin
                        r_sh  <= {i_value, {(BcdW-ValueW){1'b0}}};
                        r_cnt <= (i_cmd == CMD_BIN) ? CntBin : CntHex;
                    end else begin
                        r_sh  <= '0;
                        r_val <= dec_val;
                        r_cnt <= CntDab;
                    end
                end
                OP_DABBLE: begin
                    r_sh  <= {adj[BcdW-2:0], r_val[ValueW-1]};
                    r_val <= {r_val[ValueW-2:0], 1'b0};
                    r_cnt <= r_cnt - 1'b1;
                end
                OP_SET_DIG: r_cnt <= CntBcd;
                OP_SKIP: begin
                    if (!top_done) begin
                        r_sh  <= sh_digit;
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                OP_SHIFT: begin
                    if (!cnt_zero) begin
                        r_sh  <= sh_digit;
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_stat = '{cnt_zero: cnt_zero, top_done: top_done, is_bin: r_bin, digit: top};

    `ASSERT_NEVER(a_dabble_not_bin, i_ctl.fire && i_ctl.op == OP_DABBLE && r_bin, "dabble in binary mode")
    `ASSERT_CLK(a_set_count, (i_ctl.fire && i_ctl.op == OP_SET_DIG) |=> (r_cnt == CntBcd), "digit count not set")

endmodule

>>> hw/rtl/integer_to_ascii_formatter.sv
// Channel   | Dir | Signals                        | Contents
// slave     | in  | i_s_tvalid/o_s_tready          | tdata: value[31:0]; tuser: command[1:0]
// master    | out | o_m_tvalid/i_m_tready/o_m_tlast | tdata: char_out[6:0], bit 7 zero
//
// One request at a time; the next is taken once the newline has left the sequencer.
// Binary/hex: load, "0b"/"0x", leading-zero skip and digits over 8 or 32 digit slots, newline.
// Decimal, or swap (byte-reversed, unsigned): load, optional '-', 32 double-dabble steps,
// leading-zero skip and 10 digit slots, newline.
// A stalled output holds the sequencer on its next character step. Reset is synchronous.
`include "assert_macros.svh"

module integer_to_ascii_formatter
    import itoa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [ValueW-1:0] i_s_tdata,   // [31:0] value
    input  logic [CmdW-1:0]   i_s_tuser,   // [1:0] command
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [7:0]        o_m_tdata,   // [6:0] char_out, [7] zero
    output logic              o_m_tlast
);

    logic [PcW-1:0]   r_pc;
    logic [PcW-1:0]   n_pc;
    logic             r_out_valid;
    logic [CharW-1:0] r_char;
    logic             r_last;

    t_uword           uw;
    t_cmd             cmd;
    t_dp_ctl          ctl;
    t_dp_stat         stat;
    logic             out_free;
    logic             fire;
    logic [CharW-1:0] emit_char;

    assign uw       = ucode(r_pc);
    assign cmd      = t_cmd'(i_s_tuser);
    assign out_free = !r_out_valid || i_m_tready;
    assign fire     = (uw.emit == EM_NONE || out_free) &&
                      (uw.cond != CND_INPUT || i_s_tvalid);
    assign o_s_tready = (uw.cond == CND_INPUT);
    assign ctl = '{fire: fire, op: uw.op};

    itoa_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_value (i_s_tdata),
        .i_cmd   (cmd),
        .i_ctl   (ctl),
        .o_stat  (stat)
    );

    // next step: dispatch on the command, jump, or branch on a datapath flag
    always_comb begin
        n_pc = r_pc;
        unique case (uw.cond)
            CND_INPUT: begin
                if (cmd == CMD_BIN || cmd == CMD_HEX) begin
                    n_pc = ST_ZERO;
                end else if (cmd == CMD_DEC && i_s_tdata[ValueW-1]) begin
                    n_pc = ST_MINUS;
                end else begin
                    n_pc = ST_DABBLE;
                end
            end
            CND_ALWAYS:   n_pc = uw.target;
            CND_CNT_ZERO: n_pc = stat.cnt_zero ? uw.target : r_pc;
            CND_TOP_DONE: n_pc = stat.top_done ? uw.target : r_pc;
            default:      n_pc = ST_IDLE;
        endcase
    end

    // character of the current step
    always_comb begin
        unique case (uw.emit)
            EM_ZERO:    emit_char = ChZero;
            EM_PREFIX:  emit_char = stat.is_bin ? ChB : ChX;
            EM_MINUS:   emit_char = ChMinus;
            EM_DIGIT:   emit_char = (stat.digit >= 4'd10)
                                    ? {3'b000, stat.digit} + HexLetterOff
                                    : {3'b000, stat.digit} + ChZero;
            EM_NEWLINE: emit_char = ChNewline;
            default:    emit_char = ChZero;
        endcase
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= ST_IDLE;
        end else if (fire) begin
            r_pc <= n_pc;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && uw.emit != EM_NONE) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && uw.emit != EM_NONE) begin
            r_char <= emit_char;
            r_last <= (uw.emit == EM_NEWLINE);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_char};
    assign o_m_tlast  = r_last;

    `ASSERT_CLK(a_out_hold, ((r_out_valid && !i_m_tready) |=> $stable({r_out_valid, r_char, r_last})), "held request changed")
    `ASSERT_CLK(a_accept_busy, (i_s_tvalid && o_s_tready) |=> (r_pc != ST_IDLE), "request not started")
    `ASSERT_NEVER(a_pc_range, r_pc > ST_NL, "step counter outside program")

endmodule
